// ----- rtl/luma_deblock_edge_filter_macros.svh -----
// ============================================================================
// Luma deblocking edge filter assertion macros
// Shared assertion forms for the checker of the luma deblocking edge filter.
// ============================================================================
`ifndef LUMA_DEBLOCK_EDGE_FILTER_MACROS_SVH
`define LUMA_DEBLOCK_EDGE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LDE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define LDE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lde_pkg.sv -----
// ============================================================================
// Luma deblocking edge filter package
// Widths, codes, the alpha, beta and clip tables, the row and result types, and abs_diff.
// ============================================================================
`default_nettype none

package lde_pkg;

   localparam int PIXEL_BITS_DEFAULT = 8;

   localparam int PIXEL_W    = 8;
   localparam int QP_W       = 6;
   localparam int STRENGTH_W = 3;
   localparam int OFFSET_W   = 5;
   localparam int TC0_W      = 5;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = OFFSET_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_ALPHA_OFFSET = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BETA_OFFSET  = 1'd1;

   localparam logic [STRENGTH_W-1:0] STRENGTH_NONE   = 3'd0;
   localparam logic [STRENGTH_W-1:0] STRENGTH_BS1    = 3'd1;
   localparam logic [STRENGTH_W-1:0] STRENGTH_BS2    = 3'd2;
   localparam logic [STRENGTH_W-1:0] STRENGTH_BS3    = 3'd3;
   localparam logic [STRENGTH_W-1:0] STRENGTH_STRONG = 3'd4;

   localparam int TABLE_DEPTH = 52;
   localparam logic [QP_W-1:0] QP_MAX = 6'd51;

   localparam logic [PIXEL_W-1:0] ALPHA_LUT [0:TABLE_DEPTH-1] = '{
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd4,   8'd4,   8'd5,   8'd6,   8'd7,   8'd8,   8'd9,   8'd10,
      8'd12,  8'd13,  8'd15,  8'd17,  8'd20,  8'd22,  8'd25,  8'd28,
      8'd32,  8'd36,  8'd40,  8'd45,  8'd50,  8'd56,  8'd63,  8'd71,
      8'd80,  8'd90,  8'd101, 8'd113, 8'd127, 8'd144, 8'd162, 8'd182,
      8'd203, 8'd226, 8'd255, 8'd255
   };

   localparam logic [PIXEL_W-1:0] BETA_LUT [0:TABLE_DEPTH-1] = '{
      8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
      8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,
      8'd2,  8'd2,  8'd2,  8'd3,  8'd3,  8'd3,  8'd3,  8'd4,
      8'd4,  8'd4,  8'd6,  8'd6,  8'd7,  8'd7,  8'd8,  8'd8,
      8'd9,  8'd9,  8'd10, 8'd10, 8'd11, 8'd11, 8'd12, 8'd12,
      8'd13, 8'd13, 8'd14, 8'd14, 8'd15, 8'd15, 8'd16, 8'd16,
      8'd17, 8'd17, 8'd18, 8'd18
   };

   localparam logic [TC0_W-1:0] TC0_BS1_TABLE [0:TABLE_DEPTH-1] = '{
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1,
      5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1,
      5'd1, 5'd2, 5'd2, 5'd2, 5'd2, 5'd3, 5'd3, 5'd3,
      5'd4, 5'd4, 5'd4, 5'd5, 5'd6, 5'd6, 5'd7, 5'd8,
      5'd9, 5'd10, 5'd11, 5'd13
   };

   localparam logic [TC0_W-1:0] TC0_BS2_TABLE [0:TABLE_DEPTH-1] = '{
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd1, 5'd1,
      5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd2,
      5'd2, 5'd2, 5'd2, 5'd3, 5'd3, 5'd3, 5'd4, 5'd4,
      5'd5, 5'd5, 5'd6, 5'd7, 5'd8, 5'd8, 5'd10, 5'd11,
      5'd12, 5'd13, 5'd15, 5'd17
   };

   localparam logic [TC0_W-1:0] TC0_BS3_TABLE [0:TABLE_DEPTH-1] = '{
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
      5'd0, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1,
      5'd1, 5'd1, 5'd1, 5'd2, 5'd2, 5'd2, 5'd2, 5'd3,
      5'd3, 5'd3, 5'd4, 5'd4, 5'd4, 5'd5, 5'd6, 5'd6,
      5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd13, 5'd14, 5'd16,
      5'd18, 5'd20, 5'd23, 5'd25
   };

   typedef struct packed {
      logic [PIXEL_W-1:0]    p3;
      logic [PIXEL_W-1:0]    p2;
      logic [PIXEL_W-1:0]    p1;
      logic [PIXEL_W-1:0]    p0;
      logic [PIXEL_W-1:0]    q0;
      logic [PIXEL_W-1:0]    q1;
      logic [PIXEL_W-1:0]    q2;
      logic [PIXEL_W-1:0]    q3;
      logic [STRENGTH_W-1:0] strength;
      logic [QP_W-1:0]       qp_before;
      logic [QP_W-1:0]       qp_after;
      logic                  edge_enable;
   } row_type;

   typedef struct packed {
      logic [PIXEL_W-1:0] out_p2;
      logic [PIXEL_W-1:0] out_p1;
      logic [PIXEL_W-1:0] out_p0;
      logic [PIXEL_W-1:0] out_q0;
      logic [PIXEL_W-1:0] out_q1;
      logic [PIXEL_W-1:0] out_q2;
      logic               was_filtered;
   } result_type;

   function automatic logic [PIXEL_W-1:0] abs_diff(input logic [PIXEL_W-1:0] a,
                                                   input logic [PIXEL_W-1:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/lde_filter.sv -----
// ============================================================================
// Luma deblocking edge filter datapath
// Table lookup, edge tests and the strong and normal filters for one row.
// ============================================================================
`default_nettype none

module lde_filter
   import lde_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
   input  row_type                     row,
   input  logic signed [OFFSET_W-1:0]  alpha_offset,
   input  logic signed [OFFSET_W-1:0]  beta_offset,
   output result_type                  result
);

   localparam int DW          = PIXEL_BITS + 4;
   localparam int SW          = PIXEL_W + 3;
   localparam int SCALE_SHIFT = PIXEL_BITS - PIXEL_W;
   localparam logic signed [DW-1:0] PIX_MAX = DW'((1 << PIXEL_BITS) - 1);

   function automatic logic [QP_W-1:0] table_index(input logic [QP_W-1:0]           qp,
                                                   input logic signed [OFFSET_W-1:0] off);
      logic signed [QP_W+1:0] sum;
      logic [QP_W-1:0]        idx;
      sum = $signed({2'b00, qp}) + (QP_W+2)'(off);
      if (sum < 0) begin
         idx = '0;
      end else if (sum > $signed({2'b00, QP_MAX})) begin
         idx = QP_MAX;
      end else begin
         idx = sum[QP_W-1:0];
      end
      return idx;
   endfunction

   function automatic logic signed [DW-1:0] clamp_sym(input logic signed [DW-1:0] v,
                                                      input logic signed [DW-1:0] lim);
      logic signed [DW-1:0] r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [PIXEL_W-1:0] clip_pixel(input logic signed [DW-1:0] v);
      logic [PIXEL_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > PIX_MAX) begin
         r = PIX_MAX[PIXEL_W-1:0];
      end else begin
         r = v[PIXEL_W-1:0];
      end
      return r;
   endfunction

   logic [QP_W:0]        qp_sum;
   logic [QP_W-1:0]      qp_avg;
   logic [QP_W-1:0]      idx_a;
   logic [QP_W-1:0]      idx_b;
   logic [DW-1:0]        alpha;
   logic [DW-1:0]        beta;
   logic [TC0_W-1:0]     tc0_raw;
   logic signed [DW-1:0] c0;

   logic [PIXEL_W-1:0] d_p0q0, d_q0q1, d_p0p1, d_p0p2, d_q0q2;
   logic edge_pass, active, filt, intra_mode, gap, ap, aq;

   logic [SW-1:0] s_p0, s_p1, s_p2, s_p0w;
   logic [SW-1:0] s_q0, s_q1, s_q2, s_q0w;

   logic signed [DW-1:0] lp2, lp1, lp0, lq0, lq1, lq2;
   logic signed [DW-1:0] avg, tc, delta_raw, dif, tap_p, tap_q;
   logic signed [DW-1:0] np1, np0, nq0, nq1;

   always_comb begin
      qp_sum = {1'b0, row.qp_before} + {1'b0, row.qp_after} + (QP_W+1)'(1);
      qp_avg = qp_sum[QP_W:1];
      idx_a  = table_index(qp_avg, alpha_offset);
      idx_b  = table_index(qp_avg, beta_offset);
      alpha  = DW'(ALPHA_LUT[idx_a]) << SCALE_SHIFT;
      beta   = DW'(BETA_LUT[idx_b]) << SCALE_SHIFT;

      unique case (row.strength)
         STRENGTH_BS1: tc0_raw = TC0_BS1_TABLE[idx_a];
         STRENGTH_BS2: tc0_raw = TC0_BS2_TABLE[idx_a];
         STRENGTH_BS3: tc0_raw = TC0_BS3_TABLE[idx_a];
         default:      tc0_raw = '0;
      endcase
      c0 = DW'(tc0_raw) << SCALE_SHIFT;

      d_p0q0 = abs_diff(row.p0, row.q0);
      d_q0q1 = abs_diff(row.q0, row.q1);
      d_p0p1 = abs_diff(row.p0, row.p1);
      d_p0p2 = abs_diff(row.p0, row.p2);
      d_q0q2 = abs_diff(row.q0, row.q2);

      edge_pass = (DW'(d_p0q0) < alpha) && (DW'(d_q0q1) < beta) && (DW'(d_p0p1) < beta);
      active    = row.edge_enable &&
                  ((row.strength == STRENGTH_BS1) || (row.strength == STRENGTH_BS2) ||
                   (row.strength == STRENGTH_BS3) || (row.strength == STRENGTH_STRONG));
      filt       = active && edge_pass;
      intra_mode = (row.strength == STRENGTH_STRONG);
      ap        = DW'(d_p0p2) < beta;
      aq        = DW'(d_q0q2) < beta;
      gap       = DW'(d_p0q0) < ((alpha >> 2) + DW'(2));

      // Strong filter taps: all sums are non-negative and stay within the 11-bit SW range.
      s_p0  = SW'(row.q1) + ((SW'(row.p1) + SW'(row.p0) + SW'(row.q0)) << 1)
              + SW'(row.p2) + SW'(4);
      s_p1  = SW'(row.p2) + SW'(row.p1) + SW'(row.p0) + SW'(row.q0) + SW'(2);
      s_p2  = ((SW'(row.p3) + SW'(row.p2)) << 1) + SW'(row.p2) + SW'(row.p1)
              + SW'(row.p0) + SW'(row.q0) + SW'(4);
      s_p0w = (SW'(row.p1) << 1) + SW'(row.p0) + SW'(row.q1) + SW'(2);
      s_q0  = SW'(row.p1) + ((SW'(row.q1) + SW'(row.p0) + SW'(row.q0)) << 1)
              + SW'(row.q2) + SW'(4);
      s_q1  = SW'(row.q2) + SW'(row.q1) + SW'(row.p0) + SW'(row.q0) + SW'(2);
      s_q2  = ((SW'(row.q3) + SW'(row.q2)) << 1) + SW'(row.q2) + SW'(row.q1)
              + SW'(row.p0) + SW'(row.q0) + SW'(4);
      s_q0w = (SW'(row.q1) << 1) + SW'(row.q0) + SW'(row.p1) + SW'(2);

      // Normal filter in signed arithmetic; arithmetic shifts round towards minus infinity.
      lp2 = DW'(row.p2);
      lp1 = DW'(row.p1);
      lp0 = DW'(row.p0);
      lq0 = DW'(row.q0);
      lq1 = DW'(row.q1);
      lq2 = DW'(row.q2);

      avg       = (lp0 + lq0 + DW'(1)) >>> 1;
      tc        = c0 + DW'(ap) + DW'(aq);
      delta_raw = (((lq0 - lp0) <<< 2) + (lp1 - lq1) + DW'(4)) >>> 3;
      dif       = clamp_sym(delta_raw, tc);
      tap_p     = (lp2 + avg - (lp1 <<< 1)) >>> 1;
      tap_q     = (lq2 + avg - (lq1 <<< 1)) >>> 1;
      np1       = lp1 + clamp_sym(tap_p, c0);
      nq1       = lq1 + clamp_sym(tap_q, c0);
      np0       = lp0 + dif;
      nq0       = lq0 - dif;

      result.out_p2       = row.p2;
      result.out_p1       = row.p1;
      result.out_p0       = row.p0;
      result.out_q0       = row.q0;
      result.out_q1       = row.q1;
      result.out_q2       = row.q2;
      result.was_filtered = filt;

      if (filt && intra_mode) begin
         if (gap && ap) begin
            result.out_p0 = s_p0[SW-1:3];
            result.out_p1 = s_p1[SW-2:2];
            result.out_p2 = s_p2[SW-1:3];
         end else begin
            result.out_p0 = s_p0w[SW-2:2];
         end
         if (gap && aq) begin
            result.out_q0 = s_q0[SW-1:3];
            result.out_q1 = s_q1[SW-2:2];
            result.out_q2 = s_q2[SW-1:3];
         end else begin
            result.out_q0 = s_q0w[SW-2:2];
         end
      end else if (filt) begin
         result.out_p0 = clip_pixel(np0);
         result.out_q0 = clip_pixel(nq0);
         if (ap) begin
            result.out_p1 = clip_pixel(np1);
         end
         if (aq) begin
            result.out_q1 = clip_pixel(nq1);
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/luma_deblock_edge_filter.sv -----
// ============================================================================
// Luma deblocking edge filter
// Filters one row of eight luma pixels across a block edge per item.
//
//   Channel  Direction  Handshake            Contents
//   req      in         req_valid/req_stall  pixels p3..q3, strength, QPs, enable
//   rsp      out        rsp_valid/rsp_stall  filtered p2..q2, was_filtered
//   csr      in         csr_write            alpha_offset, beta_offset
//
// One item per cycle is sustained while rsp_stall is low; each item passes from
// acceptance to result through the input register and then the result register.
// The whole filter sits between those two registers.
// A stalled result still lets the input register take one more item.
// Synchronous reset empties both registers and zeroes the offsets.
// ============================================================================
`default_nettype none

module luma_deblock_edge_filter
   import lde_pkg::*;
#(
   parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [PIXEL_W-1:0]     req_p3,
   input  logic [PIXEL_W-1:0]     req_p2,
   input  logic [PIXEL_W-1:0]     req_p1,
   input  logic [PIXEL_W-1:0]     req_p0,
   input  logic [PIXEL_W-1:0]     req_q0,
   input  logic [PIXEL_W-1:0]     req_q1,
   input  logic [PIXEL_W-1:0]     req_q2,
   input  logic [PIXEL_W-1:0]     req_q3,
   input  logic [STRENGTH_W-1:0]  req_strength,
   input  logic [QP_W-1:0]        req_qp_before,
   input  logic [QP_W-1:0]        req_qp_after,
   input  logic                   req_edge_enable,

   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIXEL_W-1:0]     rsp_out_p2,
   output logic [PIXEL_W-1:0]     rsp_out_p1,
   output logic [PIXEL_W-1:0]     rsp_out_p0,
   output logic [PIXEL_W-1:0]     rsp_out_q0,
   output logic [PIXEL_W-1:0]     rsp_out_q1,
   output logic [PIXEL_W-1:0]     rsp_out_q2,
   output logic                   rsp_was_filtered,

   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   row_type    row_ff, row_in;
   logic       row_valid_ff, row_valid_in;
   result_type res_ff, res_in;
   result_type filt_res;
   logic       rsp_valid_ff, rsp_valid_in;

   logic signed [OFFSET_W-1:0] alpha_offset_ff, alpha_offset_in;
   logic signed [OFFSET_W-1:0] beta_offset_ff, beta_offset_in;

   logic out_load, row_load, accept;

   lde_filter #(
      .PIXEL_BITS (PIXEL_BITS)
   ) u_filter (
      .row          (row_ff),
      .alpha_offset (alpha_offset_ff),
      .beta_offset  (beta_offset_ff),
      .result       (filt_res)
   );

   always_comb begin
      out_load  = !rsp_valid_ff || !rsp_stall;
      row_load  = !row_valid_ff || out_load;
      req_stall = reset || !row_load;
      accept    = req_valid && !req_stall;

      row_in             = row_ff;
      row_valid_in       = row_valid_ff;
      res_in             = res_ff;
      rsp_valid_in       = rsp_valid_ff;
      alpha_offset_in    = alpha_offset_ff;
      beta_offset_in     = beta_offset_ff;

      if (row_load) begin
         row_valid_in = accept;
      end
      if (accept) begin
         row_in.p3          = req_p3;
         row_in.p2          = req_p2;
         row_in.p1          = req_p1;
         row_in.p0          = req_p0;
         row_in.q0          = req_q0;
         row_in.q1          = req_q1;
         row_in.q2          = req_q2;
         row_in.q3          = req_q3;
         row_in.strength    = req_strength;
         row_in.qp_before   = req_qp_before;
         row_in.qp_after    = req_qp_after;
         row_in.edge_enable = req_edge_enable;
      end
      if (out_load) begin
         rsp_valid_in = row_valid_ff;
         if (row_valid_ff) begin
            res_in = filt_res;
         end
      end

      if (csr_write) begin
         unique case (csr_index)
            CSR_ALPHA_OFFSET: alpha_offset_in = csr_wdata;
            CSR_BETA_OFFSET:  beta_offset_in  = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      res_ff <= res_in;
      if (reset) begin
         row_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         alpha_offset_ff <= '0;
         beta_offset_ff  <= '0;
      end else begin
         row_valid_ff    <= row_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         alpha_offset_ff <= alpha_offset_in;
         beta_offset_ff  <= beta_offset_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_p2       = res_ff.out_p2;
   assign rsp_out_p1       = res_ff.out_p1;
   assign rsp_out_p0       = res_ff.out_p0;
   assign rsp_out_q0       = res_ff.out_q0;
   assign rsp_out_q1       = res_ff.out_q1;
   assign rsp_out_q2       = res_ff.out_q2;
   assign rsp_was_filtered = res_ff.was_filtered;

endmodule

`default_nettype wire

// ----- rtl/lde_checker.sv -----
// ============================================================================
// Luma deblocking edge filter checker
// Port-level checks on flow, latency and the unfiltered pass-through path.
// ============================================================================
`default_nettype none

`include "luma_deblock_edge_filter_macros.svh"

module lde_checker
   import lde_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic [PIXEL_W-1:0]    req_p0,
   input logic [PIXEL_W-1:0]    req_q0,
   input logic [STRENGTH_W-1:0] req_strength,
   input logic                  req_edge_enable,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [PIXEL_W-1:0]    rsp_out_p0,
   input logic [PIXEL_W-1:0]    rsp_out_q0,
   input logic                  rsp_was_filtered
);

   // The input side may only stall while a result is held back.
   `LDE_ASSERT_IMPLY(a_no_idle_stall, clock, reset, !(rsp_valid && rsp_stall), !req_stall, "input stalled while the output side could move")

   // An accepted item reaches the output through the input and result registers unless the output is held.
   `LDE_ASSERT_NEXT(a_latency, clock, reset, (req_valid && !req_stall) ##1 !(rsp_valid && rsp_stall), rsp_valid, "accepted item did not appear on the output")

   // A disabled edge or an inactive strength passes the row through unfiltered.
   `LDE_ASSERT_NEXT(a_pass_through, clock, reset, (req_valid && !req_stall && (!req_edge_enable || req_strength == STRENGTH_NONE || req_strength > STRENGTH_STRONG)) ##1 !(rsp_valid && rsp_stall), rsp_valid && !rsp_was_filtered && rsp_out_p0 == $past(req_p0, 2) && rsp_out_q0 == $past(req_q0, 2), "unfiltered row was modified")

   // A held result stays on the output unchanged.
   `LDE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_p0) && $stable(rsp_out_q0) && $stable(rsp_was_filtered), "held result changed")

endmodule

bind luma_deblock_edge_filter lde_checker u_lde_checker (.*);

`default_nettype wire
